### rtl/c8x_pkg.sv
// ----------------------------------------------------------------------------
// CHIP-8 execute package
// Shared types and constants for the instruction execute block.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  typedef enum logic [3:0] {
    OP_RET, OP_JMP, OP_CALL, OP_SEQI, OP_SNEI, OP_SEQ, OP_SNE, OP_SETI, OP_ADDI,
    OP_ALU, OP_SETIDX, OP_JMPV0, OP_NOP, OP_GETDT, OP_SETDT, OP_SETST
  } op_t;

  typedef enum logic [1:0] {
    CLS_OK, CLS_BAD
  } cls_t;

  typedef struct packed {
    op_t        op;
    cls_t       cls;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] n;
    logic [7:0] nn;
    logic [11:0] nnn;
  } dec_t;

endpackage

### rtl/c8x_decode.sv
// ----------------------------------------------------------------------------
// CHIP-8 decode stage
// Accepts instruction beats, classifies them and holds one decoded entry.
// ----------------------------------------------------------------------------
module c8x_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              instruction_valid,
  output logic              instruction_ready,
  input  logic [15:0]       instruction,
  output logic              dec_valid,
  input  logic              dec_ready,
  output c8x_pkg::dec_t     dec
);

  c8x_pkg::dec_t dec_next;

  assign instruction_ready = !dec_valid || dec_ready;

  always_comb begin
    dec_next.x   = instruction[11:8];
    dec_next.y   = instruction[7:4];
    dec_next.n   = instruction[3:0];
    dec_next.nn  = instruction[7:0];
    dec_next.nnn = instruction[11:0];
    dec_next.cls = c8x_pkg::CLS_OK;
    dec_next.op  = c8x_pkg::OP_NOP;
    case (instruction[15:12])
      4'h0: begin
        dec_next.op = c8x_pkg::OP_RET;
        if (instruction != 16'h00EE) dec_next.cls = c8x_pkg::CLS_BAD;
      end
      4'h1: dec_next.op = c8x_pkg::OP_JMP;
      4'h2: dec_next.op = c8x_pkg::OP_CALL;
      4'h3: dec_next.op = c8x_pkg::OP_SEQI;
      4'h4: dec_next.op = c8x_pkg::OP_SNEI;
      4'h5: dec_next.op = c8x_pkg::OP_SEQ;
      4'h6: dec_next.op = c8x_pkg::OP_SETI;
      4'h7: dec_next.op = c8x_pkg::OP_ADDI;
      4'h8: begin
        dec_next.op = c8x_pkg::OP_ALU;
        if (instruction[3] && instruction[3:0] != 4'hE) dec_next.cls = c8x_pkg::CLS_BAD;
      end
      4'h9: dec_next.op = c8x_pkg::OP_SNE;
      4'hA: dec_next.op = c8x_pkg::OP_SETIDX;
      4'hB: dec_next.op = c8x_pkg::OP_JMPV0;
      4'hD: dec_next.op = c8x_pkg::OP_NOP;
      4'hF: begin
        case (instruction[7:0])
          8'h07:   dec_next.op = c8x_pkg::OP_GETDT;
          8'h15:   dec_next.op = c8x_pkg::OP_SETDT;
          8'h18:   dec_next.op = c8x_pkg::OP_SETST;
          8'h1E:   dec_next.op = c8x_pkg::OP_NOP;
          default: dec_next.cls = c8x_pkg::CLS_BAD;
        endcase
      end
      default: dec_next.cls = c8x_pkg::CLS_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (instruction_ready) begin
      dec_valid <= instruction_valid;
    end
    if (instruction_ready && instruction_valid) begin
      dec <= dec_next;
    end
  end

endmodule

### rtl/c8x_execute.sv
// ----------------------------------------------------------------------------
// CHIP-8 execute stage
// Carries out decoded instructions against the architectural state and
// registers one result beat per instruction.
// ----------------------------------------------------------------------------
module c8x_execute #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start_address_we,
  input  logic [11:0]       start_address,
  input  logic              dec_valid,
  output logic              dec_ready,
  input  c8x_pkg::dec_t     dec,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [1:0]        status,
  output logic [11:0]       next_pc,
  output logic              reg_written,
  output logic [3:0]        reg_index,
  output logic [7:0]        reg_value,
  output logic [7:0]        flag_value,
  output logic [11:0]       index_value
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [11:0] pc, pc_next;
  logic [7:0]  vregs [16];
  logic [11:0] ireg, ireg_next;
  logic [11:0] rstack [STACK_DEPTH];
  logic [LW-1:0] level, level_next;
  logic [7:0]  delay, delay_next, sound, sound_next;
  logic [1:0]  st;
  logic        wr, wr_flag, push, fire;
  logic [7:0]  res, flag, vx, vy;
  logic [8:0]  sum;
  logic [11:0] pc2, pc4;
  logic [AW-1:0] top_idx, push_idx;

  assign dec_ready = !result_valid || result_ready;
  assign fire      = dec_valid && dec_ready;
  assign vx        = vregs[dec.x];
  assign vy        = vregs[dec.y];
  assign pc2       = pc + 12'd2;
  assign pc4       = pc + 12'd4;
  assign top_idx   = AW'(level - LW'(1));
  assign push_idx  = AW'(level);

  always_comb begin
    st = c8x_pkg::ST_OK; pc_next = pc2; wr = 1'b0; res = 8'd0;
    wr_flag = 1'b0; flag = 8'd0; push = 1'b0; level_next = level;
    ireg_next = ireg; delay_next = delay; sound_next = sound;
    sum = {1'b0, vx} + {1'b0, vy};
    if (dec.cls == c8x_pkg::CLS_BAD) begin
      st = c8x_pkg::ST_BAD; pc_next = pc;
    end else begin
      case (dec.op)
        c8x_pkg::OP_RET: begin
          if (level == '0) begin
            st = c8x_pkg::ST_UNDER; pc_next = pc;
          end else begin
            level_next = level - LW'(1); pc_next = rstack[top_idx];
          end
        end
        c8x_pkg::OP_JMP: pc_next = dec.nnn;
        c8x_pkg::OP_CALL: begin
          if (level >= LW'(STACK_DEPTH)) begin
            st = c8x_pkg::ST_OVER; pc_next = pc;
          end else begin
            push = 1'b1; level_next = level + LW'(1); pc_next = dec.nnn;
          end
        end
        c8x_pkg::OP_SEQI: pc_next = (vx == dec.nn) ? pc4 : pc2;
        c8x_pkg::OP_SNEI: pc_next = (vx != dec.nn) ? pc4 : pc2;
        c8x_pkg::OP_SEQ:  pc_next = (vx == vy) ? pc4 : pc2;
        c8x_pkg::OP_SNE:  pc_next = (vx != vy) ? pc4 : pc2;
        c8x_pkg::OP_SETI: begin wr = 1'b1; res = dec.nn; end
        c8x_pkg::OP_ADDI: begin wr = 1'b1; res = vx + dec.nn; end
        c8x_pkg::OP_ALU: begin
          wr = 1'b1;
          case (dec.n)
            4'h0: res = vy;
            4'h1: res = vx | vy;
            4'h2: res = vx & vy;
            4'h3: res = vx ^ vy;
            4'h4: begin wr_flag = 1'b1; flag = {7'd0, sum[8]}; res = sum[7:0]; end
            4'h5: begin wr_flag = 1'b1; flag = {7'd0, vx >= vy}; res = vx - vy; end
            4'h6: begin wr_flag = 1'b1; flag = {7'd0, vx[0]}; res = {1'b0, vx[7:1]}; end
            4'h7: begin wr_flag = 1'b1; flag = {7'd0, vy >= vx}; res = vy - vx; end
            default: begin wr_flag = 1'b1; flag = {7'd0, vx[7]}; res = {vx[6:0], 1'b0}; end
          endcase
        end
        c8x_pkg::OP_SETIDX: ireg_next = dec.nnn;
        c8x_pkg::OP_JMPV0:  pc_next = dec.nnn + {4'd0, vregs[0]};
        c8x_pkg::OP_GETDT:  begin wr = 1'b1; res = delay; end
        c8x_pkg::OP_SETDT:  delay_next = vx;
        c8x_pkg::OP_SETST:  sound_next = vx;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 12'd512; ireg <= '0; level <= '0; delay <= '0; sound <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < 16; i++) vregs[i] <= '0;
    end else begin
      if (result_ready) result_valid <= 1'b0;
      if (start_address_we) begin
        pc <= start_address;
      end else if (fire) begin
        pc <= pc_next; ireg <= ireg_next; level <= level_next;
        delay <= delay_next; sound <= sound_next;
        if (wr_flag) vregs[15] <= flag;
        if (wr) vregs[dec.x] <= res;
        result_valid <= 1'b1;
      end
    end
    if (fire) begin
      if (push) rstack[push_idx] <= pc2;
      status      <= st;
      next_pc     <= pc_next;
      reg_written <= wr;
      reg_index   <= wr ? dec.x : 4'd0;
      reg_value   <= res;
      flag_value  <= wr && dec.x == 4'hF ? res : (wr_flag ? flag : vregs[15]);
      index_value <= ireg_next;
    end
  end

endmodule

### rtl/chip8_instruction_execute.sv
// ----------------------------------------------------------------------------
// CHIP-8 instruction execute
// Executes one fetched CHIP-8 instruction per beat and reports its effect.
// ----------------------------------------------------------------------------
// The instruction channel carries one 16-bit instruction word per beat; the
// result channel returns one beat per instruction with status, next pc, the
// register write, VF and I. A decode register classifies each beat and
// a one-entry queue hands it to the execute stage, which updates the state
// and registers the result. It passes the decode register, then the result
// register, and one instruction is taken every cycle while results drain.
// When the receiver stalls, the result register and then the decode entry
// fill before instruction_ready drops. Reset empties both stages, sets pc to
// 512 and clears V0..VF, I, the stack level and both timer values. Writing
// start_address loads pc with the value written.
module chip8_instruction_execute #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start_address_we,
  input  logic [11:0] start_address,
  input  logic        instruction_valid,
  output logic        instruction_ready,
  input  logic [15:0] instruction,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [11:0] next_pc,
  output logic        reg_written,
  output logic [3:0]  reg_index,
  output logic [7:0]  reg_value,
  output logic [7:0]  flag_value,
  output logic [11:0] index_value
);

  logic          dec_valid, dec_ready;
  c8x_pkg::dec_t dec;

  c8x_decode u_decode (
    .clk, .rst, .instruction_valid, .instruction_ready, .instruction,
    .dec_valid, .dec_ready, .dec
  );

  c8x_execute #(.STACK_DEPTH(STACK_DEPTH)) u_execute (
    .clk, .rst, .start_address_we, .start_address, .dec_valid, .dec_ready,
    .dec, .result_valid, .result_ready, .status, .next_pc, .reg_written,
    .reg_index, .reg_value, .flag_value, .index_value
  );

endmodule
